[hw/rtl/dlf_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package dlf_pkg;

  localparam int MAX_NAME_BYTES  = 16;
  localparam int LINE_COUNT_BITS = 16;

  localparam int WIN_DEPTH  = MAX_NAME_BYTES + 1;
  localparam int WIN_IDX_W  = $clog2(WIN_DEPTH);
  localparam int LEN_W      = 5;
  localparam int NAME_W     = 128;
  localparam int NAME_IDX_W = 4;
  localparam int LINE_OUT_W = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 64;

  localparam logic [CFG_IDX_W-1:0] REG_NAME_LOW  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NAME_HIGH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_NAME_LEN  = 2'd2;

  localparam logic [1:0] KIND_NONE     = 2'd0;
  localparam logic [1:0] KIND_DECL     = 2'd1;
  localparam logic [1:0] KIND_FALLBACK = 2'd2;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_LPAR  = 8'h28;
  localparam logic [7:0] CH_SEMI  = 8'h3b;
  localparam logic [7:0] CH_LT    = 8'h3c;

  typedef struct packed {
    logic shift;
    logic clr;
  } win_ctl_t;

  typedef struct packed {
    logic match;
    logic space_at_len;
  } win_stat_t;

endpackage
`default_nettype wire

[hw/rtl/dlf_byte_if.sv]
`timescale 1ns / 1ps
`default_nettype none
interface dlf_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;

  modport source (output valid, output text_byte, input ready);
  modport sink (input valid, input text_byte, output ready);
endinterface
`default_nettype wire

[hw/rtl/dlf_result_if.sv]
`timescale 1ns / 1ps
`default_nettype none
interface dlf_result_if;
  logic                                valid;
  logic                                ready;
  logic [dlf_pkg::LINE_OUT_W-1:0]      line_number;
  logic [1:0]                          line_kind;
  logic                                count_overflow;

  modport source (output valid, output line_number, output line_kind,
                  output count_overflow, input ready);
  modport sink (input valid, input line_number, input line_kind,
                input count_overflow, output ready);
endinterface
`default_nettype wire

[hw/rtl/dlf_cfg_if.sv]
`timescale 1ns / 1ps
`default_nettype none
interface dlf_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [dlf_pkg::CFG_IDX_W-1:0]     index;
  logic [dlf_pkg::CFG_DATA_W-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

[hw/rtl/dlf_cell.sv]
`timescale 1ns / 1ps
`default_nettype none
module dlf_cell (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire dlf_pkg::win_ctl_t ctl,
  input  wire logic [7:0]        byte_in,
  input  wire logic              active,
  input  wire logic [7:0]        expected,
  output logic [7:0]             byte_out,
  output logic                   hit,
  output logic                   spc
);

  logic [7:0] byte_r;
  logic [7:0] byte_nxt;

  always_comb begin
    byte_nxt = byte_r;
    if (ctl.clr) begin
      byte_nxt = 8'h00;
    end else if (ctl.shift) begin
      byte_nxt = byte_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_r <= 8'h00;
    end else begin
      byte_r <= byte_nxt;
    end
  end

  // compare on the byte this cell holds after the shift
  assign hit      = !active || (byte_in == expected);
  assign spc      = (byte_in == dlf_pkg::CH_SPACE);
  assign byte_out = byte_r;

endmodule
`default_nettype wire

[hw/rtl/dlf_window.sv]
`timescale 1ns / 1ps
`default_nettype none
module dlf_window (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire dlf_pkg::win_ctl_t             ctl,
  input  wire logic [7:0]                    din,
  input  wire logic [dlf_pkg::NAME_W-1:0]    name,
  input  wire logic [dlf_pkg::LEN_W-1:0]     len_eff,
  output dlf_pkg::win_stat_t                 stat
);

  logic [7:0]                    taps   [dlf_pkg::WIN_DEPTH];
  logic [dlf_pkg::WIN_DEPTH-1:0] hits;
  logic [dlf_pkg::WIN_DEPTH-1:0] spcs;

  for (genvar k = 0; k < dlf_pkg::WIN_DEPTH; k++) begin : g_cell
    logic [7:0]                    cell_in;
    logic [dlf_pkg::LEN_W-1:0]     pos;
    logic [dlf_pkg::NAME_IDX_W-1:0] idx;
    logic                          act;
    logic [7:0]                    exp_byte;

    if (k == 0) begin : g_head
      assign cell_in = din;
    end else begin : g_link
      assign cell_in = taps[k-1];
    end

    // cell k holds name byte len-1-k when the name ends at the newest byte
    assign pos      = len_eff - dlf_pkg::LEN_W'(k) - dlf_pkg::LEN_W'(1);
    assign idx      = pos[dlf_pkg::NAME_IDX_W-1:0];
    assign act      = (dlf_pkg::LEN_W'(k) < len_eff);
    assign exp_byte = name[{idx, 3'b000} +: 8];

    dlf_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (ctl),
      .byte_in  (cell_in),
      .active   (act),
      .expected (exp_byte),
      .byte_out (taps[k]),
      .hit      (hits[k]),
      .spc      (spcs[k])
    );
  end

  assign stat.match        = &hits;
  assign stat.space_at_len = spcs[len_eff[dlf_pkg::WIN_IDX_W-1:0]];

endmodule
`default_nettype wire

[hw/rtl/declaration_line_finder_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// a result is registered: it is on out_chan in the cycle after the line or text end request
// one byte per cycle unless a result waits; the compare in the window cells is combinational
// a waiting result holds off in_chan until out_chan takes it; the next byte enters that cycle
// reset: synchronous, active low; clears the window, counters, flags and name registers
// no clearing pass; in_chan is ready in the first cycle after reset
module declaration_line_finder_unit (
  input  wire logic clk,
  input  wire logic rst_n,
  dlf_byte_if.sink     in_chan,
  dlf_result_if.source out_chan,
  dlf_cfg_if.sink      cfg_chan
);

  localparam int LCB = dlf_pkg::LINE_COUNT_BITS;

  logic [63:0]                name_lo_r;
  logic [63:0]                name_hi_r;
  logic [dlf_pkg::LEN_W-1:0]  name_len_r;
  logic [dlf_pkg::LEN_W-1:0]  len_eff;

  logic [LCB-1:0]             line_cnt_r, line_cnt_nxt;
  logic [4:0]                 bil_r, bil_nxt;
  logic                       first_hit_r, first_hit_nxt;
  logic                       awaiting_r, awaiting_nxt;
  logic                       hit_q_r, hit_q_nxt;
  logic                       fol_semi_r, fol_semi_nxt;
  logic [7:0]                 tail_r, tail_nxt;
  logic [LCB-1:0]             fb_line_r, fb_line_nxt;
  logic                       done_r, done_nxt;
  logic                       ovf_r, ovf_nxt;

  logic                       out_valid_r;
  logic [LCB-1:0]             res_line_r, res_line_nxt;
  logic [1:0]                 res_kind_r, res_kind_nxt;
  logic                       res_ovf_r;
  logic                       emit;

  logic                       acc;
  logic [7:0]                 b;
  dlf_pkg::win_ctl_t          wctl;
  dlf_pkg::win_stat_t         wstat;
  logic [LCB+15:0]            line_wide;

  assign len_eff = (name_len_r > dlf_pkg::LEN_W'(dlf_pkg::MAX_NAME_BYTES)) ?
                   dlf_pkg::LEN_W'(dlf_pkg::MAX_NAME_BYTES) : name_len_r;

  assign in_chan.ready  = !out_valid_r || out_chan.ready;
  assign cfg_chan.ready = 1'b1;
  assign acc            = in_chan.valid && in_chan.ready;
  assign b              = in_chan.text_byte;

  dlf_window u_window (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (wctl),
    .din     (b),
    .name    ({name_hi_r, name_lo_r}),
    .len_eff (len_eff),
    .stat    (wstat)
  );

  always_comb begin
    logic is_end;
    logic hq;
    logic fs;
    logic clr_text;
    logic clr_line;

    is_end        = (b == dlf_pkg::CH_LF) || (b == dlf_pkg::CH_NUL);
    hq            = hit_q_r;
    fs            = fol_semi_r;
    clr_text      = 1'b0;
    clr_line      = 1'b0;
    emit          = 1'b0;
    res_line_nxt  = line_cnt_r;
    res_kind_nxt  = dlf_pkg::KIND_NONE;
    wctl.shift    = 1'b0;
    wctl.clr      = 1'b0;

    line_cnt_nxt  = line_cnt_r;
    bil_nxt       = bil_r;
    first_hit_nxt = first_hit_r;
    awaiting_nxt  = awaiting_r;
    hit_q_nxt     = hit_q_r;
    fol_semi_nxt  = fol_semi_r;
    tail_nxt      = tail_r;
    fb_line_nxt   = fb_line_r;
    done_nxt      = done_r;
    ovf_nxt       = ovf_r;

    if (acc) begin
      if (done_r) begin
        // early report made: skip the rest of the text
        clr_text = (b == dlf_pkg::CH_NUL);
      end else begin
        if (awaiting_r) begin
          awaiting_nxt = 1'b0;
          if ((b == dlf_pkg::CH_LPAR) || (b == dlf_pkg::CH_SPACE) ||
              (b == dlf_pkg::CH_LT) || (b == dlf_pkg::CH_SEMI)) begin
            hq = 1'b1;
            fs = (b == dlf_pkg::CH_SEMI);
          end
        end
        hit_q_nxt    = hq;
        fol_semi_nxt = fs;
        if (is_end) begin
          if ((len_eff != '0) && hq && ((tail_r != dlf_pkg::CH_SEMI) || fs)) begin
            emit         = 1'b1;
            res_line_nxt = line_cnt_r;
            res_kind_nxt = dlf_pkg::KIND_DECL;
            if (b == dlf_pkg::CH_NUL) begin
              clr_text = 1'b1;
            end else begin
              done_nxt = 1'b1;
            end
          end else begin
            if ((len_eff != '0) && hq && (fb_line_r == '0)) begin
              fb_line_nxt = line_cnt_r;
            end
            if (b == dlf_pkg::CH_NUL) begin
              emit = 1'b1;
              if ((len_eff != '0) && (fb_line_nxt != '0)) begin
                res_line_nxt = fb_line_nxt;
                res_kind_nxt = dlf_pkg::KIND_FALLBACK;
              end else begin
                res_line_nxt = '0;
                res_kind_nxt = dlf_pkg::KIND_NONE;
              end
              clr_text = 1'b1;
            end else begin
              if (&line_cnt_r) begin
                ovf_nxt = 1'b1;
              end else begin
                line_cnt_nxt = line_cnt_r + LCB'(1);
              end
              clr_line = 1'b1;
            end
          end
        end else begin
          wctl.shift = 1'b1;
          if (bil_r != 5'd31) begin
            bil_nxt = bil_r + 5'd1;
          end
          if ((b != dlf_pkg::CH_SPACE) && (b != dlf_pkg::CH_CR)) begin
            tail_nxt = b;
          end
          if ((len_eff != '0) && !first_hit_r && (bil_nxt >= len_eff) && wstat.match) begin
            first_hit_nxt = 1'b1;
            if ((bil_nxt > len_eff) && wstat.space_at_len) begin
              awaiting_nxt = 1'b1;
            end
          end
        end
      end
    end

    if (clr_line || clr_text) begin
      bil_nxt       = '0;
      first_hit_nxt = 1'b0;
      awaiting_nxt  = 1'b0;
      hit_q_nxt     = 1'b0;
      fol_semi_nxt  = 1'b0;
      tail_nxt      = '0;
    end
    if (clr_text) begin
      wctl.clr     = 1'b1;
      wctl.shift   = 1'b0;
      line_cnt_nxt = LCB'(1);
      fb_line_nxt  = '0;
      done_nxt     = 1'b0;
      ovf_nxt      = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      name_lo_r   <= '0;
      name_hi_r   <= '0;
      name_len_r  <= '0;
      line_cnt_r  <= LCB'(1);
      bil_r       <= '0;
      first_hit_r <= 1'b0;
      awaiting_r  <= 1'b0;
      hit_q_r     <= 1'b0;
      fol_semi_r  <= 1'b0;
      tail_r      <= '0;
      fb_line_r   <= '0;
      done_r      <= 1'b0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_chan.valid && cfg_chan.ready) begin
        case (cfg_chan.index)
          dlf_pkg::REG_NAME_LOW:  name_lo_r  <= cfg_chan.data;
          dlf_pkg::REG_NAME_HIGH: name_hi_r  <= cfg_chan.data;
          dlf_pkg::REG_NAME_LEN:  name_len_r <= cfg_chan.data[dlf_pkg::LEN_W-1:0];
          default: ;
        endcase
      end
      line_cnt_r  <= line_cnt_nxt;
      bil_r       <= bil_nxt;
      first_hit_r <= first_hit_nxt;
      awaiting_r  <= awaiting_nxt;
      hit_q_r     <= hit_q_nxt;
      fol_semi_r  <= fol_semi_nxt;
      tail_r      <= tail_nxt;
      fb_line_r   <= fb_line_nxt;
      done_r      <= done_nxt;
      ovf_r       <= ovf_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result payload, loaded with each request that produces a result
  always_ff @(posedge clk) begin
    if (emit) begin
      res_line_r <= res_line_nxt;
      res_kind_r <= res_kind_nxt;
      res_ovf_r  <= ovf_r;
    end
  end

  assign line_wide               = {16'h0000, res_line_r};
  assign out_chan.valid          = out_valid_r;
  assign out_chan.line_number    = line_wide[dlf_pkg::LINE_OUT_W-1:0];
  assign out_chan.line_kind      = res_kind_r;
  assign out_chan.count_overflow = res_ovf_r;

`ifndef SYNTHESIS
  a_none_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (res_kind_r == dlf_pkg::KIND_NONE) |-> (res_line_r == '0))
    else $error("none result with nonzero line");
  a_found_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (res_kind_r != dlf_pkg::KIND_NONE) |-> (res_line_r != '0))
    else $error("found result with line zero");
  a_await_after_hit: assert property (@(posedge clk) disable iff (!rst_n)
    (awaiting_r || hit_q_r) |-> first_hit_r)
    else $error("follower state without a name hit");
  a_skip_silent: assert property (@(posedge clk) disable iff (!rst_n)
    acc && done_r && !out_valid_r |=> !out_valid_r)
    else $error("result produced while skipping after early report");
`endif

endmodule
`default_nettype wire

[tb/tb_declaration_line_finder_unit.sv]
`timescale 1ns / 1ps
module tb_declaration_line_finder_unit;
  import dlf_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
  localparam logic [7:0] LETTER_FIRST = 8'h61;
  localparam logic [7:0] LETTER_LAST  = 8'h64;
  localparam int HOLD_CYCLES = 300;
  localparam int RAND_PHASES = 9;
  localparam int PHASE_ITEMS = 150;
  localparam logic [LINE_COUNT_BITS-1:0] LINE_TOP = '1;

  typedef logic [7:0] byte_q_t[$];

  typedef struct packed {
    logic [LINE_OUT_W-1:0] line_number;
    logic [1:0]            line_kind;
    logic                  count_overflow;
  } line_result_t;

  class decl_line_board;
    logic [63:0]                name_lo;
    logic [63:0]                name_hi;
    logic [LEN_W-1:0]           name_len;
    logic [7:0]                 recent [WIN_DEPTH];
    logic [LINE_COUNT_BITS-1:0] line_cnt;
    logic [4:0]                 line_bytes;
    logic [7:0]                 tail;
    logic [LINE_COUNT_BITS-1:0] fallback;
    bit first_hit, await_follow, qualified, follow_semi, done, sat_flag;
    line_result_t due_q[$];
    int errors;
    int shown;

    function new();
      name_lo = '0;
      name_hi = '0;
      name_len = '0;
      errors = 0;
      shown = 0;
      clear_text();
    endfunction

    function void clear_line();
      line_bytes = '0;
      first_hit = 1'b0;
      await_follow = 1'b0;
      qualified = 1'b0;
      follow_semi = 1'b0;
      tail = '0;
    endfunction

    function void clear_text();
      foreach (recent[i]) recent[i] = '0;
      line_cnt = 1;
      fallback = '0;
      done = 1'b0;
      sat_flag = 1'b0;
      clear_line();
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_NAME_LOW:  name_lo = data;
        REG_NAME_HIGH: name_hi = data;
        REG_NAME_LEN:  name_len = data[LEN_W-1:0];
        default: ;
      endcase
    endfunction

    function logic [7:0] name_byte(int i);
      return (i < 8) ? name_lo[8*i +: 8] : name_hi[8*(i-8) +: 8];
    endfunction

    function void queue_result(logic [LINE_COUNT_BITS-1:0] line, logic [1:0] kind);
      line_result_t r;
      r.line_number = line;
      r.line_kind = kind;
      r.count_overflow = sat_flag;
      due_q.push_back(r);
    endfunction

    // one accepted text byte
    function void note_request(logic [7:0] b);
      int unsigned len;
      bit match;
      len = (name_len > MAX_NAME_BYTES) ? MAX_NAME_BYTES : name_len;
      if (done) begin
        if (b == CH_NUL) clear_text();
        return;
      end
      if (await_follow) begin
        await_follow = 1'b0;
        if (b == CH_LPAR || b == CH_SPACE || b == CH_LT || b == CH_SEMI) begin
          qualified = 1'b1;
          follow_semi = (b == CH_SEMI);
        end
      end
      if (b == CH_LF || b == CH_NUL) begin
        if (len > 0 && qualified) begin
          if (tail != CH_SEMI || follow_semi) begin
            queue_result(line_cnt, KIND_DECL);
            if (b == CH_NUL) clear_text();
            else done = 1'b1;
            return;
          end
          if (fallback == 0) fallback = line_cnt;
        end
        if (b == CH_NUL) begin
          if (len > 0 && fallback != 0) queue_result(fallback, KIND_FALLBACK);
          else queue_result('0, KIND_NONE);
          clear_text();
          return;
        end
        if (line_cnt == LINE_TOP) sat_flag = 1'b1;
        else line_cnt++;
        clear_line();
        return;
      end
      for (int i = WIN_DEPTH - 1; i > 0; i--) recent[i] = recent[i-1];
      recent[0] = b;
      if (line_bytes < 31) line_bytes++;
      if (b != CH_SPACE && b != CH_CR) tail = b;
      if (len > 0 && !first_hit && line_bytes >= len) begin
        match = 1'b1;
        for (int i = 0; i < len; i++) begin
          if (recent[len-1-i] != name_byte(i)) match = 1'b0;
        end
        if (match) begin
          first_hit = 1'b1;
          if (line_bytes > len && recent[len] == CH_SPACE) await_follow = 1'b1;
        end
      end
    endfunction

    function void complain(string what, line_result_t got, line_result_t want);
      errors++;
      if (shown < 10) begin
        shown++;
        $display("%s: got line %0d kind %0d ovf %0d, expected line %0d kind %0d ovf %0d",
                 what, got.line_number, got.line_kind, got.count_overflow,
                 want.line_number, want.line_kind, want.count_overflow);
      end
    endfunction

    function void check_result(line_result_t got);
      line_result_t want;
      if (due_q.size() == 0) begin
        complain("unexpected result", got, '0);
        return;
      end
      want = due_q.pop_front();
      if (got.line_number !== want.line_number || got.line_kind !== want.line_kind ||
          got.count_overflow !== want.count_overflow)
        complain("result mismatch", got, want);
    endfunction

    function int pending();
      return due_q.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  bit   no_idle = 1'b0;
  logic hold_rx = 1'b0;
  event hold_go;

  logic [7:0]   cur_name [MAX_NAME_BYTES];
  int           gen_len;
  byte_q_t      text_buf;
  int           n_sent = 0;
  bit           hold_done = 1'b0;
  line_result_t seen_res;

  decl_line_board sb = new();

  dlf_byte_if   in_if();
  dlf_result_if out_if();
  dlf_cfg_if    cfg_if();

  declaration_line_finder_unit dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if),
    .cfg_chan (cfg_if)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial begin
    #40ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // result side: check taken results, then pick ready for the next cycle
  initial begin
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_if.valid && out_if.ready) begin
        seen_res.line_number = out_if.line_number;
        seen_res.line_kind = out_if.line_kind;
        seen_res.count_overflow = out_if.count_overflow;
        sb.check_result(seen_res);
      end
      if (!rst_n || hold_rx) out_if.ready <= 1'b0;
      else if (no_idle) out_if.ready <= 1'b1;
      else out_if.ready <= ($urandom_range(99) >= 17);
    end
  end

  // long receiver stall, counted here
  initial begin
    forever begin
      @(hold_go);
      hold_rx <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk);
      hold_rx <= 1'b0;
    end
  end

  task automatic push_byte(input logic [7:0] b);
    if (!no_idle) begin
      while ($urandom_range(99) < 17) begin
        in_if.valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_if.valid <= 1'b1;
    in_if.text_byte <= b;
    do @(posedge clk); while (!in_if.ready);
    sb.note_request(b);
    n_sent++;
  endtask

  task automatic send_str(input string s);
    for (int i = 0; i < s.len(); i++) push_byte(s[i]);
  endtask

  task automatic send_buf();
    foreach (text_buf[i]) push_byte(text_buf[i]);
  endtask

  task automatic wait_drain();
    in_if.valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data <= data;
    do @(posedge clk); while (!cfg_if.ready);
    sb.set_reg(idx, data);
  endtask

  task automatic set_name(input logic [63:0] lo, input logic [63:0] hi,
                          input logic [63:0] len_data, input bit spare);
    for (int i = 0; i < 8; i++) begin
      cur_name[i] = lo[8*i +: 8];
      cur_name[i+8] = hi[8*i +: 8];
    end
    gen_len = (len_data[LEN_W-1:0] > MAX_NAME_BYTES) ? MAX_NAME_BYTES : len_data[LEN_W-1:0];
    write_reg(REG_NAME_LOW, lo);
    write_reg(REG_NAME_HIGH, hi);
    write_reg(REG_NAME_LEN, len_data);
    if (spare) write_reg(REG_SPARE, {$urandom, $urandom});
    cfg_if.valid <= 1'b0;
  endtask

  function automatic logic [7:0] pick_letter();
    return 8'($urandom_range(LETTER_FIRST, LETTER_LAST));
  endfunction

  function automatic logic [63:0] letter_word();
    logic [63:0] w;
    for (int i = 0; i < 8; i++) w[8*i +: 8] = pick_letter();
    return w;
  endfunction

  function automatic void add_letters(int n);
    repeat (n) text_buf.push_back(pick_letter());
  endfunction

  function automatic void add_name(bit corrupt);
    int k;
    int pos;
    k = (gen_len == 0) ? 3 : gen_len;
    pos = $urandom_range(k - 1);
    for (int i = 0; i < k; i++) begin
      if (gen_len == 0 || (corrupt && i == pos)) text_buf.push_back(pick_letter());
      else text_buf.push_back(cur_name[i]);
    end
  endfunction

  function automatic void add_line();
    int r;
    logic [7:0] b;
    r = $urandom_range(99);
    if (r < 60) begin
      // name, mostly after a space, with a random follower and line tail
      if ($urandom_range(9) == 0) add_letters($urandom_range(30, 40));
      else if ($urandom_range(7) == 0) add_name(1'b0);
      else add_letters($urandom_range(0, 6));
      text_buf.push_back(($urandom_range(9) != 0) ? CH_SPACE : pick_letter());
      add_name($urandom_range(9) == 0);
      case ($urandom_range(5))
        0: text_buf.push_back(CH_LPAR);
        1: text_buf.push_back(CH_SPACE);
        2: text_buf.push_back(CH_LT);
        3: text_buf.push_back(CH_SEMI);
        4: text_buf.push_back(pick_letter());
        default: ;
      endcase
      add_letters($urandom_range(0, 6));
      if ($urandom_range(2) == 0) begin
        text_buf.push_back(CH_SPACE);
        add_letters($urandom_range(0, 4));
      end
      if ($urandom_range(1)) text_buf.push_back(CH_SEMI);
      repeat ($urandom_range(0, 3)) text_buf.push_back($urandom_range(1) ? CH_SPACE : CH_CR);
    end else if (r < 80) begin
      repeat ($urandom_range(0, 5)) begin
        add_letters($urandom_range(0, 5));
        case ($urandom_range(3))
          0: text_buf.push_back(CH_SPACE);
          1: text_buf.push_back(CH_SEMI);
          2: text_buf.push_back(CH_LPAR);
          default: text_buf.push_back(CH_LT);
        endcase
      end
    end else begin
      repeat ($urandom_range(0, 40)) begin
        b = 8'($urandom_range(1, 255));
        if (b == CH_LF) b = CH_SPACE;
        text_buf.push_back(b);
      end
    end
  endfunction

  function automatic void make_text();
    int n;
    text_buf.delete();
    n = $urandom_range(1, 6);
    for (int i = 0; i < n; i++) begin
      add_line();
      if (i < n - 1 || $urandom_range(1)) text_buf.push_back(CH_LF);
    end
    text_buf.push_back(CH_NUL);
  endfunction

  initial begin
    int start;
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] lenw;

    rst_n <= 1'b0;
    in_if.valid <= 1'b0;
    in_if.text_byte <= '0;
    cfg_if.valid <= 1'b0;
    cfg_if.index <= '0;
    cfg_if.data <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // short directed texts with the name "ab"
    set_name({$urandom, 16'($urandom), 8'h62, 8'h61}, {$urandom, $urandom}, 64'd2, 1'b0);
    send_str(" ab(\nx");
    push_byte(CH_NUL);
    send_str(" ab;");
    push_byte(CH_NUL);
    send_str(" ab x;");
    push_byte(CH_CR);
    send_str(" \nab(\n");
    push_byte(CH_NUL);

    for (int p = 0; p < RAND_PHASES; p++) begin
      wait_drain();
      no_idle <= (p == 1);
      lo = {$urandom, $urandom};
      hi = {$urandom, $urandom};
      lenw = '0;
      case (p)
        0: lenw = '0;
        1: begin
          lo = letter_word();
          hi = letter_word();
          lenw = 64'd16;
        end
        2: begin
          lo = letter_word();
          hi = letter_word();
          // length above the maximum, junk in the upper bits
          lenw = {32'($urandom), 27'($urandom), 5'd31};
        end
        3: begin
          lo = letter_word();
          lenw = 64'd1;
        end
        4: begin
          lo = '1;
          hi = '1;
          lenw = 64'd16;
        end
        5: begin
          lo = letter_word();
          lo[15:8] = $urandom_range(1) ? CH_NUL : CH_LF;
          lenw = 64'd4;
        end
        6: begin
          lo = letter_word();
          lenw = 64'($urandom_range(2, 8));
        end
        7: begin
          lo = letter_word();
          hi = letter_word();
          lenw = 64'($urandom_range(9, 15));
        end
        default: begin
          lo = '0;
          hi = '0;
          lenw = 64'd5;
        end
      endcase
      set_name(lo, hi, lenw, p == 5);
      start = n_sent;
      while (n_sent - start < PHASE_ITEMS) begin
        if (p == 3 && !hold_done && n_sent - start >= 60) begin
          // receiver stalls while short texts pile up results
          -> hold_go;
          repeat (40) begin
            push_byte(CH_NUL);
            if ($urandom_range(7) == 0) begin
              make_text();
              send_buf();
            end
          end
          wait_drain();
          hold_done = 1'b1;
        end
        make_text();
        send_buf();
      end
    end

    wait_drain();
    repeat (10) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
